// ----- rtl/ssr_pkg.sv -----
// Package: shared types, widths and the launcher angle segment table.
package ssr_pkg;

    localparam int IN_W        = 16;
    localparam int SUM_W       = 33;
    localparam int ROOT_W      = 17;
    localparam int TEST_W      = 34;
    localparam int RANGE_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int RPM_W       = 13;
    localparam int SEG_N       = 11;
    localparam int SEG_W       = 4;
    localparam int T_W         = 14;
    localparam int M_W         = 13;
    localparam int P_W         = T_W + M_W;
    localparam int Q_W         = 25;
    localparam int BASE_W      = 17;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 39;
    localparam int PROD_W      = Q_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int ANG_SUM_W   = 20;
    localparam int CFG_IDX_W   = 3;

    localparam logic [RPM_W-1:0]  WHEEL_LOW   = 13'd4000;
    localparam logic [RPM_W-1:0]  WHEEL_HIGH  = 13'd6500;
    localparam logic [ROOT_W-1:0] WHEEL_KNEE  = 17'd1750;
    localparam logic [ROOT_W-1:0] WHEEL_CAP_D = 17'd2250;

    localparam logic [63:0] RECIP_9000_L = ((64'd1 << RECIP_SHIFT) + 64'd8999) / 64'd9000;
    localparam logic [63:0] RECIP_1000_L = ((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000;
    localparam logic [63:0] RECIP_500_L  = ((64'd1 << RECIP_SHIFT) + 64'd499) / 64'd500;
    localparam logic [63:0] RECIP_250_L  = ((64'd1 << RECIP_SHIFT) + 64'd249) / 64'd250;
    localparam logic [RECIP_W-1:0] RECIP_9000 = RECIP_9000_L[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_1000_L[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_500  = RECIP_500_L[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_250  = RECIP_250_L[RECIP_W-1:0];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLUE_X = 3'd0,
        CFG_BLUE_Y = 3'd1,
        CFG_RED_X  = 3'd2,
        CFG_RED_Y  = 3'd3,
        CFG_TRIM   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] blue_x;
        logic signed [IN_W-1:0] blue_y;
        logic signed [IN_W-1:0] red_x;
        logic signed [IN_W-1:0] red_y;
        logic signed [IN_W-1:0] angle_trim;
    } t_cfg;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] launch_angle;
        logic [RPM_W-1:0]   wheel_rpm;
    } t_rsp;

    // angle = base - floor((m*t + dm1) / D), t = d - x0
    typedef struct packed {
        logic [ROOT_W-1:0]  x0;
        logic [BASE_W-1:0]  base;
        logic [M_W-1:0]     m;
        logic [RECIP_W-1:0] recip;
        logic [T_W-1:0]     dm1;
    } t_seg;

    localparam t_seg SEG_TAB [SEG_N] = '{
        '{17'd0,    17'd32768, 13'd0,    RECIP_1000, 14'd0},
        '{17'd6000, 17'd36045, 13'd3277, RECIP_9000, 14'd8999},
        '{17'd5000, 17'd37356, 13'd1311, RECIP_1000, 14'd999},
        '{17'd4000, 17'd40416, 13'd3060, RECIP_1000, 14'd999},
        '{17'd3500, 17'd40960, 13'd544,  RECIP_500,  14'd499},
        '{17'd3000, 17'd43909, 13'd2949, RECIP_500,  14'd499},
        '{17'd2500, 17'd46531, 13'd2622, RECIP_500,  14'd499},
        '{17'd2000, 17'd52429, 13'd5898, RECIP_500,  14'd499},
        '{17'd1750, 17'd54395, 13'd1966, RECIP_250,  14'd249},
        '{17'd1500, 17'd56361, 13'd1966, RECIP_250,  14'd249},
        // below 1.5 m: origin moved to 0 mm, base folded in
        '{17'd0,    17'd74055, 13'd5898, RECIP_500,  14'd499}
    };

endpackage

// ----- rtl/ssr_req_if.sv -----
// Interface: request channel carrying the robot pose and side flag.
interface ssr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssr_pkg::IN_W-1:0]      robot_x;
    logic signed [ssr_pkg::IN_W-1:0]      robot_y;
    logic                                 side_second;

    modport source (output valid, output robot_x, output robot_y, output side_second,
                    input ready);
    modport sink   (input valid, input robot_x, input robot_y, input side_second,
                    output ready);
endinterface

// ----- rtl/ssr_rsp_if.sv -----
// Interface: response channel carrying range and shooter setpoints.
interface ssr_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ssr_pkg::RANGE_W-1:0]       range_mm;
    logic [ssr_pkg::ANGLE_W-1:0]       launch_angle;
    logic [ssr_pkg::RPM_W-1:0]         wheel_rpm;

    modport source (output valid, output range_mm, output launch_angle, output wheel_rpm,
                    input ready);
    modport sink   (input valid, input range_mm, input launch_angle, input wheel_rpm,
                    output ready);
endinterface

// ----- rtl/ssr_dist.sv -----
// Distance front end: target select, |dx| and |dy|, squares and their sum.
module ssr_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [ssr_pkg::IN_W-1:0]   i_robot_x,
    input  logic signed [ssr_pkg::IN_W-1:0]   i_robot_y,
    input  logic                              i_side_second,
    input  ssr_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output logic [ssr_pkg::SUM_W-1:0]         o_sum
);

    localparam int W = ssr_pkg::IN_W;

    logic signed [W:0]   w_dx;
    logic signed [W:0]   w_dy;
    logic signed [W-1:0] w_tx;
    logic signed [W-1:0] w_ty;
    logic [W:0]          w_ax;
    logic [W:0]          w_ay;

    logic                r_v1, r_v2, r_v3;
    logic [W-1:0]        r_ax, r_ay;
    logic [2*W-1:0]      r_sqx, r_sqy;
    logic [ssr_pkg::SUM_W-1:0] r_sum;

    always_comb begin
        w_tx = i_side_second ? i_cfg.red_x : i_cfg.blue_x;
        w_ty = i_side_second ? i_cfg.red_y : i_cfg.blue_y;
        w_dx = {w_tx[W-1], w_tx} - {i_robot_x[W-1], i_robot_x};
        w_dy = {w_ty[W-1], w_ty} - {i_robot_y[W-1], i_robot_y};
        w_ax = w_dx[W] ? (~w_dx + 1'b1) : w_dx;
        w_ay = w_dy[W] ? (~w_dy + 1'b1) : w_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= w_ax[W-1:0];
            r_ay  <= w_ay[W-1:0];
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

endmodule

// ----- rtl/ssr_sqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
module ssr_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [ssr_pkg::SUM_W-1:0]         i_sum,
    output logic                              o_valid,
    output logic [ssr_pkg::ROOT_W-1:0]        o_root
);

    localparam int RW = ssr_pkg::ROOT_W;
    localparam int SW = ssr_pkg::SUM_W;
    localparam int TW = ssr_pkg::TEST_W;

    logic [SW-1:0] w_rem_in  [RW+1];
    logic [RW-1:0] w_root_in [RW+1];
    logic          w_v_in    [RW+1];

    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic          r_v    [RW];

    assign w_rem_in[0]  = i_sum;
    assign w_root_in[0] = '0;
    assign w_v_in[0]    = i_valid;

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            localparam int BI = RW - 1 - k;
            logic [TW-1:0] w_test;
            logic          w_take;

            always_comb begin
                w_test = ({{(TW-RW){1'b0}}, w_root_in[k]} << (BI + 1))
                       + ({{(TW-1){1'b0}}, 1'b1} << (2 * BI));
                w_take = {{(TW-SW){1'b0}}, w_rem_in[k]} >= w_test;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= w_v_in[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= w_take ? (w_rem_in[k] - w_test[SW-1:0]) : w_rem_in[k];
                    r_root[k] <= w_take ? (w_root_in[k] | (RW'(1) << BI)) : w_root_in[k];
                end
            end

            assign w_rem_in[k+1]  = r_rem[k];
            assign w_root_in[k+1] = r_root[k];
            assign w_v_in[k+1]    = r_v[k];
        end
    endgenerate

    assign o_valid = w_v_in[RW];
    assign o_root  = w_root_in[RW];

endmodule

// ----- rtl/ssr_map.sv -----
// Range to setpoints: segment pick, interpolation by reciprocal, trim, clamp, wheel.
module ssr_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [ssr_pkg::ROOT_W-1:0]        i_dist,
    input  logic signed [ssr_pkg::IN_W-1:0]   i_trim,
    output logic                              o_valid,
    output ssr_pkg::t_rsp                     o_rsp
);

    localparam int RW = ssr_pkg::ROOT_W;
    localparam int NS = 6;

    typedef struct packed {
        logic [ssr_pkg::RANGE_W-1:0] range_mm;
        logic [ssr_pkg::RPM_W-1:0]   wheel_rpm;
    } t_carry;

    logic [ssr_pkg::SEG_W-1:0] w_seg;
    t_carry                    w_carry;
    logic [8:0]                w_over;
    logic [RW-1:0]             w_t;
    logic [ssr_pkg::QUOT_W-1:0]   w_quot;
    logic signed [ssr_pkg::ANG_SUM_W-1:0] w_ang;
    logic [ssr_pkg::ANGLE_W-1:0]  w_ang_sat;

    logic                      r_v [NS];
    logic [RW-1:0]             r_dist1;
    logic [ssr_pkg::SEG_W-1:0] r_seg1, r_seg2, r_seg3, r_seg4, r_seg5;
    t_carry                    r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [ssr_pkg::T_W-1:0]   r_t2;
    logic [ssr_pkg::P_W-1:0]   r_p3;
    logic [ssr_pkg::Q_W-1:0]   r_q4;
    logic [ssr_pkg::PROD_W-1:0] r_prod5;
    logic [ssr_pkg::ANGLE_W-1:0] r_ang6;

    always_comb begin
        if      (i_dist > 17'd15000) w_seg = 4'd0;
        else if (i_dist > 17'd6000)  w_seg = 4'd1;
        else if (i_dist > 17'd5000)  w_seg = 4'd2;
        else if (i_dist > 17'd4000)  w_seg = 4'd3;
        else if (i_dist >= 17'd3500) w_seg = 4'd4;
        else if (i_dist >= 17'd3000) w_seg = 4'd5;
        else if (i_dist >= 17'd2500) w_seg = 4'd6;
        else if (i_dist >= 17'd2000) w_seg = 4'd7;
        else if (i_dist >= 17'd1750) w_seg = 4'd8;
        else if (i_dist >= 17'd1500) w_seg = 4'd9;
        else                         w_seg = 4'd10;

        w_carry.range_mm = i_dist[RW-1] ? '1 : i_dist[ssr_pkg::RANGE_W-1:0];
        w_over = i_dist[8:0] - ssr_pkg::WHEEL_KNEE[8:0];
        if (i_dist >= ssr_pkg::WHEEL_CAP_D) begin
            w_carry.wheel_rpm = ssr_pkg::WHEEL_HIGH;
        end else if (i_dist > ssr_pkg::WHEEL_KNEE) begin
            w_carry.wheel_rpm = ssr_pkg::WHEEL_LOW
                              + {2'b0, w_over, 2'b0} + {4'b0, w_over};
        end else begin
            w_carry.wheel_rpm = ssr_pkg::WHEEL_LOW;
        end
    end

    assign w_t = r_dist1 - ssr_pkg::SEG_TAB[r_seg1].x0;

    always_comb begin
        w_quot = r_prod5[ssr_pkg::PROD_W-1:ssr_pkg::RECIP_SHIFT];
        w_ang  = signed'({3'b0, ssr_pkg::SEG_TAB[r_seg5].base})
               - signed'({2'b0, w_quot})
               + ssr_pkg::ANG_SUM_W'(i_trim);
        if (w_ang < 0) begin
            w_ang_sat = '0;
        end else if (w_ang > signed'({4'b0, {ssr_pkg::ANGLE_W{1'b1}}})) begin
            w_ang_sat = '1;
        end else begin
            w_ang_sat = w_ang[ssr_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist1 <= i_dist;
            r_seg1  <= w_seg;
            r_c1    <= w_carry;

            r_t2    <= (r_seg1 == 4'd0) ? '0 : w_t[ssr_pkg::T_W-1:0];
            r_seg2  <= r_seg1;
            r_c2    <= r_c1;

            r_p3    <= ssr_pkg::SEG_TAB[r_seg2].m * r_t2;
            r_seg3  <= r_seg2;
            r_c3    <= r_c2;

            r_q4    <= r_p3[ssr_pkg::Q_W-1:0]
                     + {{(ssr_pkg::Q_W-ssr_pkg::T_W){1'b0}}, ssr_pkg::SEG_TAB[r_seg3].dm1};
            r_seg4  <= r_seg3;
            r_c4    <= r_c3;

            r_prod5 <= r_q4 * ssr_pkg::SEG_TAB[r_seg4].recip;
            r_seg5  <= r_seg4;
            r_c5    <= r_c4;

            r_ang6  <= w_ang_sat;
            r_c6    <= r_c5;
        end
    end

    assign o_valid            = r_v[NS-1];
    assign o_rsp.range_mm     = r_c6.range_mm;
    assign o_rsp.launch_angle = r_ang6;
    assign o_rsp.wheel_rpm    = r_c6.wheel_rpm;

endmodule

// ----- rtl/ssr_skid.sv -----
// Output register with one skid entry; its ready is a register output.
module ssr_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ssr_pkg::t_rsp    i_data,
    output logic             o_ready,
    output logic             o_valid,
    output ssr_pkg::t_rsp    o_data,
    input  logic             i_ready
);

    logic          r_out_v;
    logic          r_sk_v;
    ssr_pkg::t_rsp r_out;
    ssr_pkg::t_rsp r_sk;
    logic          w_push;
    logic          w_drain;

    assign w_push  = i_valid && !r_sk_v;
    assign w_drain = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (w_drain) begin
            r_out_v <= r_sk_v || w_push;
            r_sk_v  <= 1'b0;
        end else if (w_push) begin
            r_sk_v  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_out <= r_sk_v ? r_sk : i_data;
        end else if (w_push) begin
            r_sk  <= i_data;
        end
    end

    assign o_ready = !r_sk_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ----- rtl/shooter_setpoint_from_range_core.sv -----
// Top level: shooter setpoints from robot range to the selected target.
//
//  channel  dir  handshake        payload
//  i_req    in   valid / ready    robot_x, robot_y, side_second
//  o_rsp    out  valid / ready    range_mm, launch_angle, wheel_rpm
//  i_cfg_*  in   write enable     index 0..4, 16-bit data
//
// One request per cycle while i_req.ready is high, up to the output register.
// The square root makes up most of the pipeline, one result bit per pipeline stage.
// Synchronous active-low reset clears valid bits and config registers.
// All stages hold together while the output skid entry is full; i_req.ready
// is that entry's empty flag, so back-pressure never drops or repeats a request.
module shooter_setpoint_from_range_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ssr_req_if.sink                             i_req,
    ssr_rsp_if.source                           o_rsp,
    input  logic                                i_cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssr_pkg::IN_W-1:0]            i_cfg_data
);

    ssr_pkg::t_cfg              r_cfg;
    logic                       w_en;
    logic                       w_sum_v;
    logic [ssr_pkg::SUM_W-1:0]  w_sum;
    logic                       w_root_v;
    logic [ssr_pkg::ROOT_W-1:0] w_root;
    logic                       w_map_v;
    ssr_pkg::t_rsp              w_map;
    logic                       w_out_v;
    ssr_pkg::t_rsp              w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssr_pkg::CFG_BLUE_X: r_cfg.blue_x     <= i_cfg_data;
                ssr_pkg::CFG_BLUE_Y: r_cfg.blue_y     <= i_cfg_data;
                ssr_pkg::CFG_RED_X:  r_cfg.red_x      <= i_cfg_data;
                ssr_pkg::CFG_RED_Y:  r_cfg.red_y      <= i_cfg_data;
                ssr_pkg::CFG_TRIM:   r_cfg.angle_trim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = w_en;

    ssr_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_req.valid),
        .i_robot_x     (i_req.robot_x),
        .i_robot_y     (i_req.robot_y),
        .i_side_second (i_req.side_second),
        .i_cfg         (r_cfg),
        .o_valid       (w_sum_v),
        .o_sum         (w_sum)
    );

    ssr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_v),
        .i_sum   (w_sum),
        .o_valid (w_root_v),
        .o_root  (w_root)
    );

    ssr_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_root_v),
        .i_dist  (w_root),
        .i_trim  (r_cfg.angle_trim),
        .o_valid (w_map_v),
        .o_rsp   (w_map)
    );

    ssr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_v),
        .i_data  (w_map),
        .o_ready (w_en),
        .o_valid (w_out_v),
        .o_data  (w_out),
        .i_ready (o_rsp.ready)
    );

    assign o_rsp.valid        = w_out_v;
    assign o_rsp.range_mm     = w_out.range_mm;
    assign o_rsp.launch_angle = w_out.launch_angle;
    assign o_rsp.wheel_rpm    = w_out.wheel_rpm;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> o_rsp.valid)
        else $error("skid entry full while output register empty");

    a_rpm_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.wheel_rpm >= ssr_pkg::WHEEL_LOW)
                     && (o_rsp.wheel_rpm <= ssr_pkg::WHEEL_HIGH))
        else $error("wheel rpm outside 4000..6500");

    a_rpm_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.range_mm >= 16'd2250) |-> o_rsp.wheel_rpm == ssr_pkg::WHEEL_HIGH)
        else $error("wheel rpm not capped at long range");

    a_far_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.range_mm > 16'd15000 && r_cfg.angle_trim == '0)
        |-> o_rsp.launch_angle == 16'd32768)
        else $error("far range angle not fixed at one half");

endmodule
